[rtl/core/lpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Landmark payload encoder package
// Shared item types, register indexes and encoding constants.
// ----------------------------------------------------------------------------
package lpe_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Largest number of payload bytes that one item can cause.
  localparam int MAX_BYTES = 12;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MARK_TYPE    = 3'd0,
    REG_TIME_TO_LIVE = 3'd1,
    REG_LAYER        = 3'd2,
    REG_WIND_ENABLE  = 3'd3,
    REG_WIND_SECTORS = 3'd4,
    REG_DIAMETER_M   = 3'd5,
    REG_ALT_LOW      = 3'd6,
    REG_ALT_HIGH     = 3'd7
  } reg_index_t;

  // Item commands.
  localparam logic CMD_COORD = 1'b0;
  localparam logic CMD_TEXT  = 1'b1;

  // Landmark type codes that change the byte layout.
  localparam logic [3:0] TYPE_TEXT      = 4'd0;
  localparam logic [3:0] TYPE_LINE_LO   = 4'd1;
  localparam logic [3:0] TYPE_LINE_HI   = 4'd4;
  localparam logic [3:0] TYPE_CIRCLE_A  = 4'd5;
  localparam logic [3:0] TYPE_CIRCLE_B  = 4'd6;
  localparam logic [3:0] TYPE_AREA_ALT  = 4'd8;
  localparam logic [3:0] TYPE_CIRC_ALT  = 4'd9;

  // Coordinates are degrees scaled by 2^23.
  localparam int          DEG_SHIFT  = 23;
  localparam logic [31:0] HALF_DEG   = 32'h0040_0000;
  localparam logic [31:0] LAT_BOUND  = 32'd754974720;   // 90 degrees
  localparam logic [31:0] LON_BOUND  = 32'd1509949440;  // 180 degrees
  localparam logic [16:0] LAT_SCALE  = 17'd93206;
  localparam logic [16:0] LON_SCALE  = 17'd46603;

  // Compressed form: fraction times 32767, clamped.
  localparam int          FRAC_SHIFT = 15;
  localparam logic [14:0] FRAC_MAX   = 15'd16383;

  // Diameter: q = diameter / 50 by reciprocal multiply, exact over 16 bits.
  localparam logic [16:0] DIAM_RECIP = 17'd83887;
  localparam int          DIAM_SHIFT = 22;
  localparam logic [10:0] DIAM_LIN   = 11'h07F;
  localparam logic [7:0]  DIAM_HMAX  = 8'h7F;
  localparam logic [7:0]  DIAM_FLAG  = 8'h80;

  // Header bit that marks the wind byte.
  localparam logic [7:0]  WIND_FLAG  = 8'h10;

  typedef struct packed {
    logic              cmd;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic [7:0]        text_byte;
    logic              last_item;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } result_t;

endpackage

[rtl/core/lpe_item_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Landmark input item channel
// Valid/ready channel that carries one coordinate or text item.
// ----------------------------------------------------------------------------
interface lpe_item_if;
  logic           valid;
  logic           ready;
  lpe_pkg::item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/lpe_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Landmark result channel
// Valid/ready channel that carries one payload byte.
// ----------------------------------------------------------------------------
interface lpe_result_if;
  logic             valid;
  logic             ready;
  lpe_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/landmark_payload_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Landmark payload encoder
// Turns landmark registers and a stream of coordinate and text items into
// the landmark payload, one byte per result item.
// ----------------------------------------------------------------------------
// An accepted item passes an input register and a multiply register, and its
// bytes are then loaded into a 12-entry output shift register, from which its
// first byte can leave. That shift register hands out one byte per cycle while
// the receiver is ready, and an item yields up to 12 bytes for a first
// coordinate with header, 4 for later line coordinates, 6 to 9 for a first
// coordinate whose header went out with an earlier item, 1 for text. Items that
// yield no byte pass through without being loaded into the shift register. The
// front stages keep accepting while earlier bytes drain, until both hold a
// waiting item, so the sustained rate is one byte per cycle while the receiver is ready.
// Configuration registers may be written only while no item is in flight.
// ----------------------------------------------------------------------------
module landmark_payload_encoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [lpe_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [lpe_pkg::CFG_DATA_W-1:0]  wr_data,
  lpe_item_if.sink                        items,
  lpe_result_if.source                    results
);

  localparam int CNT_W_L = lpe_pkg::CNT_W;

  typedef struct packed {
    logic hdr;
    logic absf;
    logic rel;
    logic text;
    logic circ;
    logic last;
  } flags_t;

  // Per-axis values between the multiply stage and the byte stage.
  typedef struct packed {
    logic [47:0] prod;
    logic        neg;
    logic        dm0;
    logic [22:0] rmag;
    logic        fneg;
  } axis_t;

  // Magnitude of a 32-bit two's complement value.
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Prepares one axis: scaled product (zero beyond the bound) and compressed-form terms.
  function automatic axis_t axis_prep(input logic [31:0] s, input logic [31:0] bound,
                                      input logic [16:0] scale);
    axis_t       a;
    logic [31:0] m;
    logic [30:0] mc;
    logic [32:0] rsum;
    logic [9:0]  dm;
    logic [33:0] r;
    logic [33:0] rabs;
    m    = mag32(s);
    mc   = (m > bound) ? 31'd0 : m[30:0];
    rsum = {1'b0, m} + {1'b0, lpe_pkg::HALF_DEG};
    dm   = rsum[32:23];
    r    = {2'b00, m} - {1'b0, dm, 23'd0};
    rabs = r[33] ? (34'd0 - r) : r;
    a.prod = 48'(mc) * 48'(scale);
    a.neg  = s[31];
    a.dm0  = dm[0];
    a.rmag = rabs[22:0];
    a.fneg = s[31] ^ r[33];
    return a;
  endfunction

  // Absolute form: rounded 24-bit value.
  function automatic logic [23:0] abs_word(input axis_t a);
    logic [47:0] sum;
    logic [24:0] q;
    sum = a.prod + 48'(lpe_pkg::HALF_DEG);
    q   = sum[47:23];
    return a.neg ? 24'(25'd0 - q) : q[23:0];
  endfunction

  // Compressed form: 15-bit fraction and odd-degree bit.
  function automatic logic [15:0] rel_word(input axis_t a);
    logic [37:0] p;
    logic [14:0] fm;
    logic [14:0] fw;
    p  = {a.rmag, 15'd0} - {15'd0, a.rmag};
    fm = p[37:23];
    if (fm > lpe_pkg::FRAC_MAX) begin
      fm = lpe_pkg::FRAC_MAX;
    end
    fw = a.fneg ? (15'd0 - fm) : fm;
    return {a.dm0, fw};
  endfunction

  // Configuration registers.
  logic [3:0]        mark_type;
  logic [3:0]        time_to_live;
  logic [3:0]        layer;
  logic              wind_enable;
  logic [7:0]        wind_sectors;
  logic [15:0]       diameter_m;
  logic signed [7:0] alt_low;
  logic signed [7:0] alt_high;

  // Message state.
  logic header_done;
  logic message_closed;
  logic coord_seen;
  logic coord_next;

  // Decisions for the item at the input.
  logic   is_line;
  logic   is_circle;
  logic   coord_prior;
  flags_t acc_flags;
  logic   item_acc;

  // Stage registers.
  logic               s1_valid;
  flags_t             s1_flags;
  logic signed [31:0] s1_lat;
  logic signed [31:0] s1_lon;
  logic [7:0]         s1_text;

  logic       s2_valid;
  flags_t     s2_flags;
  axis_t      s2_lat;
  axis_t      s2_lon;
  logic [7:0] s2_text;
  logic [7:0] s2_diam;

  logic [CNT_W_L-1:0] rem;
  logic [7:0]         s3_bytes [lpe_pkg::MAX_BYTES];
  logic               s3_last;

  // Pipeline control.
  logic s2_nonempty;
  logic s3_free;
  logic load3;
  logic s2_ready;
  logic res_acc;

  // Diameter code.
  logic [32:0] diam_prod;
  logic [10:0] diam_q;
  logic [7:0]  diam_h;
  logic [7:0]  diam_code;

  // Byte list for the item in stage two.
  logic [7:0]         pack_bytes [lpe_pkg::MAX_BYTES];
  logic [CNT_W_L-1:0] pos;
  logic [23:0]        lat_abs;
  logic [23:0]        lon_abs;
  logic [15:0]        lat_rel;
  logic [15:0]        lon_rel;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mark_type    <= '0;
      time_to_live <= '0;
      layer        <= '0;
      wind_enable  <= 1'b0;
      wind_sectors <= '0;
      diameter_m   <= '0;
      alt_low      <= '0;
      alt_high     <= '0;
    end else if (wr_en) begin
      unique case (lpe_pkg::reg_index_t'(wr_index))
        lpe_pkg::REG_MARK_TYPE:    mark_type    <= wr_data[3:0];
        lpe_pkg::REG_TIME_TO_LIVE: time_to_live <= wr_data[3:0];
        lpe_pkg::REG_LAYER:        layer        <= wr_data[3:0];
        lpe_pkg::REG_WIND_ENABLE:  wind_enable  <= wr_data[0];
        lpe_pkg::REG_WIND_SECTORS: wind_sectors <= wr_data[7:0];
        lpe_pkg::REG_DIAMETER_M:   diameter_m   <= wr_data;
        lpe_pkg::REG_ALT_LOW:      alt_low      <= wr_data[7:0];
        lpe_pkg::REG_ALT_HIGH:     alt_high     <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  // Decide at acceptance which parts of the payload this item produces.
  always_comb begin
    is_line   = ((mark_type >= lpe_pkg::TYPE_LINE_LO) && (mark_type <= lpe_pkg::TYPE_LINE_HI))
                || (mark_type == lpe_pkg::TYPE_AREA_ALT);
    is_circle = (mark_type == lpe_pkg::TYPE_CIRCLE_A) || (mark_type == lpe_pkg::TYPE_CIRCLE_B)
                || (mark_type == lpe_pkg::TYPE_CIRC_ALT);
    coord_prior    = coord_seen && !message_closed;
    coord_next     = coord_prior;
    acc_flags      = '0;
    acc_flags.hdr  = !(header_done && !message_closed);
    acc_flags.last = items.payload.last_item;
    if (items.payload.cmd == lpe_pkg::CMD_COORD) begin
      if (is_line) begin
        acc_flags.rel  = coord_prior;
        acc_flags.absf = !coord_prior;
        coord_next     = 1'b1;
      end else if (((mark_type == lpe_pkg::TYPE_TEXT) || is_circle) && !coord_prior) begin
        acc_flags.absf = 1'b1;
        acc_flags.circ = is_circle;
        coord_next     = 1'b1;
      end
    end else if ((mark_type == lpe_pkg::TYPE_TEXT) && coord_prior) begin
      acc_flags.text = 1'b1;
    end
  end

  // Handshake and stage advance.
  assign s2_nonempty = s2_flags.hdr | s2_flags.absf | s2_flags.rel | s2_flags.text;
  assign res_acc     = results.valid && results.ready;
  assign s3_free     = (rem == '0) || (results.ready && (rem == CNT_W_L'(1)));
  assign load3       = s2_valid && s2_nonempty && s3_free;
  assign s2_ready    = !s2_valid || !s2_nonempty || s3_free;
  assign items.ready = !s1_valid || s2_ready;
  assign item_acc    = items.valid && items.ready;

  // Message state follows each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_done    <= 1'b0;
      message_closed <= 1'b0;
      coord_seen     <= 1'b0;
    end else if (item_acc) begin
      header_done    <= 1'b1;
      message_closed <= items.payload.last_item;
      coord_seen     <= coord_next;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      s1_flags <= acc_flags;
      s1_lat   <= items.payload.latitude;
      s1_lon   <= items.payload.longitude;
      s1_text  <= items.payload.text_byte;
    end
  end

  // Diameter divided by 50 through a reciprocal multiply, then the byte code.
  always_comb begin
    diam_prod = 33'(diameter_m) * 33'(lpe_pkg::DIAM_RECIP);
    diam_q    = diam_prod[lpe_pkg::DIAM_SHIFT+10:lpe_pkg::DIAM_SHIFT];
    diam_h    = (diam_q[10:3] > lpe_pkg::DIAM_HMAX) ? lpe_pkg::DIAM_HMAX : diam_q[10:3];
    diam_code = (diam_q > lpe_pkg::DIAM_LIN) ? (lpe_pkg::DIAM_FLAG + diam_h) : diam_q[7:0];
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_flags <= s1_flags;
      s2_lat   <= axis_prep(s1_lat, lpe_pkg::LAT_BOUND, lpe_pkg::LAT_SCALE);
      s2_lon   <= axis_prep(s1_lon, lpe_pkg::LON_BOUND, lpe_pkg::LON_SCALE);
      s2_text  <= s1_text;
      s2_diam  <= diam_code;
    end
  end

  // Lay out the bytes of this item in transmit order.
  always_comb begin
    lat_abs    = abs_word(s2_lat);
    lon_abs    = abs_word(s2_lon);
    lat_rel    = rel_word(s2_lat);
    lon_rel    = rel_word(s2_lon);
    pack_bytes = '{default: 8'h00};
    pos        = '0;
    if (s2_flags.hdr) begin
      pack_bytes[pos] = {time_to_live, mark_type};
      pos = pos + CNT_W_L'(1);
      pack_bytes[pos] = {4'h0, layer} | (wind_enable ? lpe_pkg::WIND_FLAG : 8'h00);
      pos = pos + CNT_W_L'(1);
      if (wind_enable) begin
        pack_bytes[pos] = wind_sectors;
        pos = pos + CNT_W_L'(1);
      end
      if (mark_type == lpe_pkg::TYPE_AREA_ALT) begin
        pack_bytes[pos] = alt_low;
        pos = pos + CNT_W_L'(1);
        pack_bytes[pos] = alt_high;
        pos = pos + CNT_W_L'(1);
      end
    end
    if (s2_flags.absf) begin
      pack_bytes[pos] = lat_abs[7:0];
      pos = pos + CNT_W_L'(1);
      pack_bytes[pos] = lat_abs[15:8];
      pos = pos + CNT_W_L'(1);
      pack_bytes[pos] = lat_abs[23:16];
      pos = pos + CNT_W_L'(1);
      pack_bytes[pos] = lon_abs[7:0];
      pos = pos + CNT_W_L'(1);
      pack_bytes[pos] = lon_abs[15:8];
      pos = pos + CNT_W_L'(1);
      pack_bytes[pos] = lon_abs[23:16];
      pos = pos + CNT_W_L'(1);
      if (s2_flags.circ) begin
        pack_bytes[pos] = s2_diam;
        pos = pos + CNT_W_L'(1);
        if (mark_type == lpe_pkg::TYPE_CIRC_ALT) begin
          pack_bytes[pos] = alt_low;
          pos = pos + CNT_W_L'(1);
          pack_bytes[pos] = alt_high;
          pos = pos + CNT_W_L'(1);
        end
      end
    end
    if (s2_flags.rel) begin
      pack_bytes[pos] = lat_rel[7:0];
      pos = pos + CNT_W_L'(1);
      pack_bytes[pos] = lat_rel[15:8];
      pos = pos + CNT_W_L'(1);
      pack_bytes[pos] = lon_rel[7:0];
      pos = pos + CNT_W_L'(1);
      pack_bytes[pos] = lon_rel[15:8];
      pos = pos + CNT_W_L'(1);
    end
    if (s2_flags.text) begin
      pack_bytes[pos] = s2_text;
      pos = pos + CNT_W_L'(1);
    end
  end

  // Output shift register: the head byte is shown, the rest move up on each take.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load3) begin
      rem <= pos;
    end else if (res_acc) begin
      rem <= rem - CNT_W_L'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      s3_bytes <= pack_bytes;
      s3_last  <= s2_flags.last;
    end else if (res_acc) begin
      for (int i = 0; i < lpe_pkg::MAX_BYTES - 1; i++) begin
        s3_bytes[i] <= s3_bytes[i+1];
      end
    end
  end

  assign results.valid             = (rem != '0);
  assign results.payload.out_byte  = s3_bytes[0];
  assign results.payload.last_byte = s3_last && (rem == CNT_W_L'(1));

`ifndef SYNTH
  // A loaded byte list is never empty.
  a_load_nonempty: assert property (@(posedge clk) disable iff (rst)
    load3 |=> results.valid)
    else $error("output stage loaded with no bytes");

  // A closing item closes the message.
  a_close: assert property (@(posedge clk) disable iff (rst)
    item_acc && items.payload.last_item |=> message_closed)
    else $error("message not closed after last item");

  // The first item of a message carries the header.
  a_header: assert property (@(posedge clk) disable iff (rst)
    item_acc && (message_closed || !header_done) |=> s1_flags.hdr)
    else $error("first item of message lost its header");

  // A stalled item in the multiply stage is held.
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_ready |=> s2_valid)
    else $error("multiply stage dropped an item");
`endif

endmodule
